FILE: hw/rtl/mlcd_pkg.sv
`timescale 1ns / 1ps

package mlcd_pkg;

  // Pixel store: one bit per entry, 13-bit pixel address
  localparam int STORE_AW    = 13;
  localparam int STORE_DEPTH = 2 ** STORE_AW;

  // Access codes carried in the command field
  localparam logic [1:0] CMD_CTRL_WRITE  = 2'd0;
  localparam logic [1:0] CMD_STATUS_READ = 2'd1;
  localparam logic [1:0] CMD_DATA_WRITE  = 2'd2;
  localparam logic [1:0] CMD_DATA_READ   = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] bus_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [5:0] contrast_level;
    logic [5:0] scroll_row;
    logic       display_enabled;
  } rsp_t;

  // Shared add/subtract unit
  typedef struct packed {
    logic [STORE_AW-1:0] a;
    logic [STORE_AW-1:0] b;
    logic                sub;
  } alu_op_t;

  typedef struct packed {
    logic [STORE_AW-1:0] sum;
    logic                borrow;
  } alu_res_t;

  // Pixel store access
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] addr;
    logic                wdata;
  } store_req_t;

endpackage

FILE: hw/rtl/mlcd_alu.sv
`timescale 1ns / 1ps

module mlcd_alu (
  input  mlcd_pkg::alu_op_t  op,
  output mlcd_pkg::alu_res_t res
);
  import mlcd_pkg::*;

  logic [STORE_AW:0] full;

  // top bit is carry on add, borrow (a < b) on subtract
  always_comb begin
    if (op.sub) begin
      full = {1'b0, op.a} - {1'b0, op.b};
    end else begin
      full = {1'b0, op.a} + {1'b0, op.b};
    end
  end

  assign res.sum    = full[STORE_AW-1:0];
  assign res.borrow = full[STORE_AW];

endmodule

FILE: hw/rtl/mlcd_store.sv
`timescale 1ns / 1ps

module mlcd_store (
  input  logic                 clk,
  input  mlcd_pkg::store_req_t req,
  output logic                 rdata
);
  import mlcd_pkg::*;

  logic mem [0:STORE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

FILE: hw/rtl/mlcd_seq.sv
`timescale 1ns / 1ps

module mlcd_seq #(
  parameter int ROW_WIDTH = 120,
  parameter int ROW_COUNT = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  mlcd_pkg::req_t       req,
  output logic                 busy,
  input  logic                 out_ready,
  output logic                 done,
  output mlcd_pkg::rsp_t       result,
  output mlcd_pkg::alu_op_t    alu_op,
  input  mlcd_pkg::alu_res_t   alu_res,
  output mlcd_pkg::store_req_t store_req,
  input  logic                 store_rdata
);
  import mlcd_pkg::*;

  localparam int COLS8 = ROW_WIDTH / 8;
  localparam int COLS6 = ROW_WIDTH / 6;
  localparam logic [STORE_AW-1:0] RW_WIDE = STORE_AW'(ROW_WIDTH);
  localparam logic [6:0] ROW_CNT7 = 7'(ROW_COUNT);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_BASE  = 3'd3;
  localparam logic [2:0] S_XFER  = 3'd4;
  localparam logic [2:0] S_STEP  = 3'd5;
  localparam logic [2:0] S_MOD   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]          state;
  logic [STORE_AW-1:0] clr_addr;
  logic [5:0]          row_ptr;
  logic [4:0]          col_ptr;
  logic [5:0]          top_row;
  logic [5:0]          contrast;
  logic                step_cols;
  logic                step_up;
  logic                eight_bit;
  logic                panel_on;
  logic                is_read;
  logic [7:0]          wbyte;
  logic [7:0]          rd;
  logic [3:0]          cnt;
  logic [STORE_AW-1:0] prod;
  logic [STORE_AW-1:0] colw;
  logic [STORE_AW-1:0] base;
  logic [6:0]          mval;
  logic                rvalid;

  logic [3:0] wlen;
  logic [6:0] col_count;
  logic [6:0] step_count;
  logic [2:0] bit_idx;

  always_comb begin
    wlen       = eight_bit ? 4'd8 : 4'd6;
    col_count  = eight_bit ? 7'(COLS8) : 7'(COLS6);
    step_count = step_cols ? col_count : ROW_CNT7;
    // first pixel of the word sits in bit wlen-1
    bit_idx    = 3'(wlen - 4'd1 - cnt);
  end

  // operand select for the shared adder
  always_comb begin
    alu_op = '0;
    unique case (state)
      S_BASE: begin
        alu_op.a = prod;
        alu_op.b = colw;
      end
      S_XFER: begin
        alu_op.a = base;
        alu_op.b = {9'd0, cnt};
      end
      S_STEP: begin
        alu_op.a   = step_cols ? {8'd0, col_ptr} : {7'd0, row_ptr};
        alu_op.b   = STORE_AW'(1);
        alu_op.sub = !step_up;
      end
      S_MOD: begin
        alu_op.a   = {6'd0, mval};
        alu_op.b   = {6'd0, step_count};
        alu_op.sub = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (state == S_CLEAR) begin
      store_req.we    = 1'b1;
      store_req.addr  = clr_addr;
      store_req.wdata = 1'b0;
    end else begin
      store_req.we    = (state == S_XFER) && !is_read && (cnt < wlen);
      store_req.addr  = alu_res.sum;
      store_req.wdata = wbyte[bit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      row_ptr   <= '0;
      col_ptr   <= '0;
      top_row   <= '0;
      contrast  <= '0;
      step_cols <= 1'b0;
      step_up   <= 1'b1;
      eight_bit <= 1'b1;
      panel_on  <= 1'b0;
      rvalid    <= 1'b0;
    end else begin
      rvalid <= (state == S_XFER) && is_read && (cnt < wlen);
      if (rvalid) begin
        rd <= {rd[6:0], store_rdata};
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            unique case (req.command) inside
              CMD_CTRL_WRITE: begin
                rd    <= '0;
                state <= S_DONE;
                // leading set bit selects the target; op-amp and test codes
                // have no visible effect
                if (req.bus_data[7:6] == 2'b11) begin
                  contrast <= req.bus_data[5:0];
                end else if (req.bus_data[7]) begin
                  row_ptr <= req.bus_data[5:0];
                end else if (req.bus_data[6]) begin
                  top_row <= req.bus_data[5:0];
                end else if (req.bus_data[5]) begin
                  col_ptr <= req.bus_data[4:0];
                end else if (req.bus_data[4] || req.bus_data[3]) begin
                  ;
                end else if (req.bus_data[2]) begin
                  step_cols <= req.bus_data[1];
                  step_up   <= req.bus_data[0];
                end else if (req.bus_data[1]) begin
                  panel_on <= req.bus_data[0];
                end else begin
                  eight_bit <= req.bus_data[0];
                end
              end
              CMD_STATUS_READ: begin
                rd    <= {1'b0, eight_bit, panel_on, 3'b000, step_cols, step_up};
                state <= S_DONE;
              end
              CMD_DATA_WRITE, CMD_DATA_READ: begin
                wbyte   <= req.bus_data;
                is_read <= (req.command == CMD_DATA_READ);
                rd      <= '0;
                cnt     <= '0;
                state   <= S_MUL;
              end
            endcase
          end
        end
        S_MUL: begin
          prod <= {7'd0, row_ptr} * RW_WIDE;
          colw <= eight_bit ? {5'd0, col_ptr, 3'b000}
                            : ({6'd0, col_ptr, 2'b00} + {7'd0, col_ptr, 1'b0});
          state <= S_BASE;
        end
        S_BASE: begin
          base  <= alu_res.sum;
          state <= S_XFER;
        end
        S_XFER: begin
          // one pixel per cycle; read bits come back from the registered store output
          if (cnt == wlen) begin
            state <= S_STEP;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_STEP: begin
          if (step_up) begin
            mval  <= alu_res.sum[6:0];
            state <= S_MOD;
          end else begin
            state <= S_DONE;
            if (step_cols) begin
              col_ptr <= (col_ptr == '0) ? 5'(col_count - 7'd1) : alu_res.sum[4:0];
            end else begin
              row_ptr <= (row_ptr == '0) ? 6'(ROW_CNT7 - 7'd1) : alu_res.sum[5:0];
            end
          end
        end
        S_MOD: begin
          // repeated subtract until below the count
          if (!alu_res.borrow) begin
            mval <= alu_res.sum[6:0];
          end else begin
            state <= S_DONE;
            if (step_cols) begin
              col_ptr <= mval[4:0];
            end else begin
              row_ptr <= mval[5:0];
            end
          end
        end
        S_DONE: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  assign result.read_data       = rd;
  assign result.contrast_level  = contrast;
  assign result.scroll_row      = top_row;
  assign result.display_enabled = panel_on;

endmodule

FILE: hw/rtl/mono_lcd_controller_ports.sv
`timescale 1ns / 1ps

// Monochrome LCD controller, one CPU port access per item.
// req channel: req_valid/req_stall with req.command (control write, status
// read, data write, data read) and req.bus_data. rsp channel: rsp_valid/
// rsp_stall with one item per request: read_data (zero on writes), contrast,
// scroll row and display-on as they stand after the access.
// Control writes and status reads go from acceptance straight to a done state,
// from which rsp_valid is registered. Data accesses run bit-serially through a
// single-port pixel store, one pixel per cycle for a word of w = 6 or 8
// pixels, then step the pointer through the shared adder; an upward step
// also reduces it modulo the count by repeated subtraction.
// req_stall falls in the same cycle as rsp_valid rises, so the next item can
// be taken while the result is still offered.
// One access is in flight at a time; req_stall is high while it runs.
// Reset: after rst the pixel store is cleared one pixel per cycle, a pass over
// all 8192 pixels during which req_stall stays high.
// The result sits in an output register; while rsp_stall holds it, the
// block finishes no further access and keeps req_stall high once the next
// access reaches its end.
module mono_lcd_controller_ports #(
  parameter int ROW_WIDTH = 120,
  parameter int ROW_COUNT = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  mlcd_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mlcd_pkg::rsp_t rsp
);
  import mlcd_pkg::*;

  logic       busy;
  logic       done;
  logic       out_ready;
  rsp_t       result;
  alu_op_t    alu_op;
  alu_res_t   alu_res;
  store_req_t store_req;
  logic       store_rdata;

  // output register is free when empty or being taken this cycle
  assign out_ready = !rsp_valid || !rsp_stall;
  assign req_stall = busy;

  mlcd_seq #(
    .ROW_WIDTH (ROW_WIDTH),
    .ROW_COUNT (ROW_COUNT)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req         (req),
    .busy        (busy),
    .out_ready   (out_ready),
    .done        (done),
    .result      (result),
    .alu_op      (alu_op),
    .alu_res     (alu_res),
    .store_req   (store_req),
    .store_rdata (store_rdata)
  );

  mlcd_alu u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

  mlcd_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (store_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done && out_ready) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_ready) begin
      rsp <= result;
    end
  end

endmodule

FILE: hw/rtl/mlcd_checker.sv
`timescale 1ns / 1ps

module mlcd_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input mlcd_pkg::rsp_t rsp
);
  import mlcd_pkg::*;

  // held result stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  // clearing pass keeps the request side closed
  a_reset_stall: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request taken during store clear");

  // one access at a time
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second access taken while one is in flight");

  // a new result only shows up at the end of a running access
  a_rsp_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result without an access in flight");

endmodule

bind mono_lcd_controller_ports mlcd_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps

// Bench for the mono LCD controller. Accesses are queued up front, sent by a
// clocked driver and checked by a clocked monitor against an in-bench model
// of the controller that is updated as each item is accepted.
module tb;
  import mlcd_pkg::*;

  localparam int ROW_WIDTH    = 120;
  localparam int ROW_COUNT    = 64;
  localparam int RANDOM_ITEMS = 1000;
  // Quiet cycles tolerated: covers the store clear of all 8192 pixels after reset
  // plus the long receiver hold-off, with plenty of margin.
  localparam int QUIET_LIMIT  = 40000;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  mono_lcd_controller_ports #(
    .ROW_WIDTH(ROW_WIDTH),
    .ROW_COUNT(ROW_COUNT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  wire req_fire = req_valid && !req_stall;
  wire rsp_fire = rsp_valid && !rsp_stall;

  // Stimulus and expectations
  req_t cpu_accesses[$];
  rsp_t pending_rsp[$];
  int   total_items = 0;
  int   n_sent = 0;
  int   n_rsp = 0;
  int   n_errors = 0;

  // Controller state as the bench sees it
  bit         pixels[STORE_DEPTH];
  logic [5:0] row_ptr = '0;
  logic [4:0] col_ptr = '0;
  logic [5:0] top_row = '0;
  logic [5:0] contrast = '0;
  logic [1:0] amp_one = '0;
  logic [1:0] amp_two = '0;
  logic       step_cols = 1'b0;
  logic       step_up = 1'b1;
  logic       eight_bit = 1'b1;
  logic       panel_on = 1'b0;

  function automatic void add_access(input logic [1:0] cmd, input logic [7:0] data);
    req_t a;
    a.command  = cmd;
    a.bus_data = data;
    cpu_accesses.push_back(a);
  endfunction

  task automatic flag_error(input string msg);
    $display("mismatch at item %0d: %s", n_rsp, msg);
    n_errors++;
  endtask

  // Apply one CPU access to the bench state and queue the result it yields.
  task automatic lcd_access(input req_t a);
    rsp_t        r;
    int unsigned w, base, cnt;
    int          i;
    logic [7:0]  v, rd;
    w    = eight_bit ? 8 : 6;
    base = row_ptr * ROW_WIDTH + col_ptr * w;
    v    = a.bus_data;
    rd   = '0;
    case (a.command)
      CMD_CTRL_WRITE: begin
        // leading set bit picks the register
        if (v[7:6] == 2'b11) contrast = v[5:0];
        else if (v[7]) row_ptr = v[5:0];
        else if (v[6]) top_row = v[5:0];
        else if (v[5]) col_ptr = v[4:0];
        else if (v[4:3] == 2'b11) ; // test mode: ignored
        else if (v[4]) amp_one = v[1:0];
        else if (v[3]) amp_two = v[1:0];
        else if (v[2]) begin
          step_cols = v[1];
          step_up   = v[0];
        end else if (v[1]) panel_on = v[0];
        else eight_bit = v[0];
      end
      CMD_STATUS_READ: begin
        rd = {1'b0, eight_bit, panel_on, 3'b000, step_cols, step_up};
      end
      CMD_DATA_WRITE: begin
        // first pixel comes from the top bit of the word
        for (i = 0; i < w; i++)
          pixels[(base + i) % STORE_DEPTH] = v[w - 1 - i];
      end
      default: begin
        for (i = 0; i < w; i++)
          rd = {rd[6:0], pixels[(base + i) % STORE_DEPTH]};
      end
    endcase
    if (a.command == CMD_DATA_WRITE || a.command == CMD_DATA_READ) begin
      // pointer steps along the chosen axis; an out-of-range pointer
      // wraps modulo the count on an upward step
      if (step_cols) begin
        cnt = ROW_WIDTH / w;
        if (step_up) col_ptr = 5'((col_ptr + 1) % cnt);
        else col_ptr = (col_ptr == 0) ? 5'(cnt - 1) : col_ptr - 5'd1;
      end else begin
        cnt = ROW_COUNT;
        if (step_up) row_ptr = 6'((row_ptr + 1) % cnt);
        else row_ptr = (row_ptr == 0) ? 6'(cnt - 1) : row_ptr - 6'd1;
      end
    end
    r.read_data       = rd;
    r.contrast_level  = contrast;
    r.scroll_row      = top_row;
    r.display_enabled = panel_on;
    pending_rsp.push_back(r);
  endtask

  // Idle rates per third of the run: receiver quiet then sender quiet, then
  // both running flat out.
  function automatic int send_idle_pct();
    if (n_sent < total_items / 3) return 9;
    if (n_sent < 2 * total_items / 3) return 75;
    return 0;
  endfunction

  function automatic int recv_stall_pct();
    if (n_rsp < total_items / 3) return 75;
    if (n_rsp < 2 * total_items / 3) return 9;
    return 0;
  endfunction

  // Driver: a new item is loaded only when the slot is empty or the current
  // one goes through at this edge, so a held payload never changes.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_fire) begin
        lcd_access(req);
        n_sent <= n_sent + 1;
      end
      if (!req_valid || req_fire) begin
        if (cpu_accesses.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
          req       <= cpu_accesses.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off: once in the flat-out third, keep the receiver off for a
  // stretch while the driver keeps offering, so the controller backs up and
  // stalls its input.
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && n_rsp >= 2 * total_items / 3 + 20) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end
    end
  end

  // Monitor: compares each result with the oldest expectation.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_fire) begin
        if (pending_rsp.size() == 0) begin
          flag_error($sformatf("result with nothing expected: %h", rsp));
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.read_data !== want.read_data)
            flag_error($sformatf("read_data got %h want %h", rsp.read_data, want.read_data));
          if (rsp.contrast_level !== want.contrast_level)
            flag_error($sformatf("contrast_level got %h want %h",
                                 rsp.contrast_level, want.contrast_level));
          if (rsp.scroll_row !== want.scroll_row)
            flag_error($sformatf("scroll_row got %h want %h", rsp.scroll_row, want.scroll_row));
          if (rsp.display_enabled !== want.display_enabled)
            flag_error($sformatf("display_enabled got %b want %b",
                                 rsp.display_enabled, want.display_enabled));
        end
        n_rsp <= n_rsp + 1;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_stall_pct());
      end
    end
  end

  // Watchdog: too long without any item moving on either channel.
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || req_fire || rsp_fire) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int         n, pick, lead;
    logic [7:0] b;

    // Directed part. Reset status first, then every register class at its
    // extremes, a column set beyond the panel so the word runs into the
    // next row, wrap on an upward step from out of range, wrap on a
    // downward step from zero, test mode, and 6-bit words with the top bits
    // of the written byte dropped.
    add_access(CMD_STATUS_READ, 8'hFF);
    add_access(CMD_CTRL_WRITE, 8'hFF);   // contrast 63
    add_access(CMD_CTRL_WRITE, 8'h7F);   // scroll row 63
    add_access(CMD_CTRL_WRITE, 8'hBF);   // row 63
    add_access(CMD_CTRL_WRITE, 8'h3F);   // column 31, past the panel edge
    add_access(CMD_DATA_WRITE, 8'hA5);
    add_access(CMD_CTRL_WRITE, 8'h07);   // step columns, upward
    add_access(CMD_CTRL_WRITE, 8'h3F);
    add_access(CMD_DATA_READ, 8'h00);    // reads at row 0, column wraps
    add_access(CMD_CTRL_WRITE, 8'h03);   // display on
    add_access(CMD_STATUS_READ, 8'h00);
    add_access(CMD_CTRL_WRITE, 8'h1B);   // test mode
    add_access(CMD_CTRL_WRITE, 8'h13);   // amp one
    add_access(CMD_CTRL_WRITE, 8'h0B);   // amp two
    add_access(CMD_CTRL_WRITE, 8'h00);   // 6-bit words
    add_access(CMD_CTRL_WRITE, 8'h20);   // column 0
    add_access(CMD_CTRL_WRITE, 8'h06);   // step columns, downward
    add_access(CMD_DATA_WRITE, 8'hFF);   // column 0 wraps down to the last
    add_access(CMD_CTRL_WRITE, 8'h20);
    add_access(CMD_CTRL_WRITE, 8'h04);   // step rows, downward
    add_access(CMD_DATA_READ, 8'hFF);
    add_access(CMD_CTRL_WRITE, 8'h80);   // row 0
    add_access(CMD_DATA_READ, 8'h00);    // row 0 wraps down to 63
    add_access(CMD_CTRL_WRITE, 8'h01);   // 8-bit words
    add_access(CMD_CTRL_WRITE, 8'h05);   // step rows, upward
    add_access(CMD_CTRL_WRITE, 8'hC0);   // contrast 0
    add_access(CMD_CTRL_WRITE, 8'h40);   // scroll row 0
    add_access(CMD_CTRL_WRITE, 8'h02);   // display off
    add_access(CMD_STATUS_READ, 8'h55);

    // Random part: mostly data traffic, with control writes spread over every
    // decode class by choosing the position of the leading set bit.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99);
      b    = 8'($urandom);
      if (pick < 25) begin
        lead = $urandom_range(7);
        if (pick >= 3)
          b = (8'h80 >> lead) | (b & ((8'h80 >> lead) - 8'd1));
        add_access(CMD_CTRL_WRITE, b);
      end else if (pick < 32) begin
        add_access(CMD_STATUS_READ, b);
      end else if (pick < 70) begin
        add_access(CMD_DATA_WRITE, b);
      end else begin
        add_access(CMD_DATA_READ, b);
      end
    end
    total_items = cpu_accesses.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Drain: look at negedges so the driver's edge activity has settled.
    while (cpu_accesses.size() > 0 || req_valid || pending_rsp.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0 && pending_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
